### hdl/arxh_pkg.sv
// ----------------------------------------------------------------------------
// ARX four-lane hash package
// Shared types, constants and the multiplier constant table of the hash block.
// ----------------------------------------------------------------------------
package arxh_pkg;

  localparam int unsigned LENGTH_BITS_DEFAULT = 32;
  localparam int unsigned IN_QUEUE_DEPTH      = 4;
  localparam int unsigned OUT_QUEUE_DEPTH     = 2;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned ROT_W       = 6;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [WORD_W-1:0] PHI   = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] MUL_A = 64'h85EBCA77C2B2AE3D;
  localparam logic [WORD_W-1:0] MUL_B = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] MUL_C = 64'h94D049BB133111EB;

  localparam int unsigned FIN_SHIFT_A = 29;
  localparam int unsigned FIN_SHIFT_B = 31;
  localparam int unsigned FIN_SHIFT_C = 37;
  localparam int unsigned FIN_SHIFT_D = 41;

  localparam logic [WORD_W-1:0] SEED_RESET      = '0;
  localparam logic [ROT_W-1:0]  ROT_ONE_RESET   = 6'd11;
  localparam logic [ROT_W-1:0]  ROT_TWO_RESET   = 6'd19;
  localparam logic [ROT_W-1:0]  ROT_THREE_RESET = 6'd35;
  localparam logic [ROT_W-1:0]  ROT_FOUR_RESET  = 6'd47;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SEED      = 3'd0,
    REG_ROT_ONE   = 3'd1,
    REG_ROT_TWO   = 3'd2,
    REG_ROT_THREE = 3'd3,
    REG_ROT_FOUR  = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    LANE_ONE   = 2'd0,
    LANE_TWO   = 2'd1,
    LANE_THREE = 2'd2,
    LANE_FOUR  = 2'd3
  } lane_t;

  typedef enum logic [2:0] {
    JOB_BASE       = 3'd0,
    JOB_LANE_ONE   = 3'd1,
    JOB_LANE_TWO   = 3'd2,
    JOB_LANE_THREE = 3'd3,
    JOB_LANE_FOUR  = 3'd4,
    JOB_FIN_A      = 3'd5,
    JOB_FIN_B      = 3'd6,
    JOB_FIN_C      = 3'd7
  } job_t;

  typedef struct packed {
    logic [WORD_W-1:0] seed;
    logic [ROT_W-1:0]  rot_one;
    logic [ROT_W-1:0]  rot_two;
    logic [ROT_W-1:0]  rot_three;
    logic [ROT_W-1:0]  rot_four;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              first;
    logic              last;
    logic              upd;
    lane_t             lane;
    logic [LEN_W-1:0]  length;
  } item_t;

  function automatic logic [WORD_W-1:0] job_mult(input job_t job);
    logic [WORD_W-1:0] k;
    case (job)
      JOB_BASE:       k = PHI;
      JOB_LANE_ONE:   k = PHI;
      JOB_LANE_TWO:   k = MUL_A;
      JOB_LANE_THREE: k = MUL_B;
      JOB_LANE_FOUR:  k = MUL_C;
      JOB_FIN_A:      k = MUL_A;
      JOB_FIN_B:      k = MUL_B;
      JOB_FIN_C:      k = PHI;
      default:        k = PHI;
    endcase
    return k;
  endfunction

endpackage

### hdl/arxh_fifo.sv
// ----------------------------------------------------------------------------
// ARX hash queue
// Short first-word-fall-through queue built from shifting register slots.
// ----------------------------------------------------------------------------
module arxh_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count;
  logic [CW-1:0]    wr_idx;
  logic [WIDTH-1:0] slot [DEPTH];
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = wr_en && !full;
  assign do_pop  = rd_en && !empty;
  assign wr_idx  = count - CW'(do_pop);
  assign rd_data = slot[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    if (i < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (do_push && (wr_idx == CW'(i))) begin
          slot[i] <= wr_data;
        end else if (do_pop) begin
          slot[i] <= slot[i+1];
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (do_push && (wr_idx == CW'(i))) begin
          slot[i] <= wr_data;
        end
      end
    end
  end

endmodule

### hdl/arxh_front.sv
// ----------------------------------------------------------------------------
// ARX hash front end
// Tracks message length and word position and classifies each word.
// ----------------------------------------------------------------------------
module arxh_front #(
  parameter int unsigned LENGTH_BITS = arxh_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [arxh_pkg::WORD_W-1:0]   data_word,
  input  logic                          first_word,
  input  logic                          last_word,
  input  logic [arxh_pkg::LEN_W-1:0]    message_length,
  input  logic                          q_full,
  output logic                          q_push,
  output arxh_pkg::item_t               q_item
);

  localparam int unsigned LEN_W = arxh_pkg::LEN_W;
  localparam int unsigned LW    = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
  localparam int unsigned PW    = LW - 2;

  logic [LW-1:0]                 bytes_total;
  logic [LW-1:0]                 bytes_total_next;
  logic [PW-1:0]                 word_position;
  logic [PW-1:0]                 word_position_next;
  logic [LW-1:0]                 cur_len;
  logic [PW-1:0]                 cur_pos;
  logic [LW-4:0]                 block_words;
  logic [LW:0]                   start;
  logic [LW:0]                   remain;
  logic                          in_block;
  logic                          in_tail;
  logic                          remain_small;
  logic                          accept;
  logic [arxh_pkg::WORD_W-1:0]   tail_mask;

  always_comb begin
    accept       = push && !q_full;
    cur_len      = first_word ? message_length[LW-1:0] : bytes_total;
    cur_pos      = first_word ? '0 : word_position;
    block_words  = {cur_len[LW-1:5], 2'b00};
    in_block     = cur_pos < {1'b0, block_words};
    start        = {cur_pos, 3'b000};
    in_tail      = start < {1'b0, cur_len};
    remain       = {1'b0, cur_len} - start;
    remain_small = (remain[LW:3] == '0);
    for (int b = 0; b < 8; b++) begin
      tail_mask[8*b +: 8] = (!remain_small || (3'(b) < remain[2:0])) ? 8'hFF : 8'h00;
    end

    q_item.word   = in_block ? data_word : (data_word & tail_mask);
    q_item.first  = first_word;
    q_item.last   = last_word;
    q_item.upd    = in_block || in_tail;
    q_item.lane   = in_block ? arxh_pkg::lane_t'(cur_pos[1:0]) : arxh_pkg::LANE_ONE;
    q_item.length = LEN_W'(cur_len);

    word_position_next = (cur_pos == '1) ? cur_pos : cur_pos + PW'(1);
    bytes_total_next   = cur_len;

    q_push = accept;
    full   = q_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_total   <= '0;
      word_position <= '0;
    end else if (accept) begin
      bytes_total   <= bytes_total_next;
      word_position <= word_position_next;
    end
  end

endmodule

### hdl/arxh_back.sv
// ----------------------------------------------------------------------------
// ARX hash back end
// Lane update, lane seeding and finalization on a shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module arxh_back (
  input  logic                          clk,
  input  logic                          rst,
  input  arxh_pkg::cfg_t                cfg,
  input  logic                          q_empty,
  input  arxh_pkg::item_t               q_item,
  output logic                          q_pop,
  input  logic                          oq_full,
  output logic                          oq_push,
  output logic [arxh_pkg::WORD_W-1:0]   oq_data
);

  localparam int unsigned W = arxh_pkg::WORD_W;

  localparam logic [1:0] STEP_LOW     = 2'd0;
  localparam logic [1:0] STEP_CROSS_A = 2'd1;
  localparam logic [1:0] STEP_CROSS_B = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_MUL  = 5'b00100,
    S_WORD = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  arxh_pkg::job_t              job;
  arxh_pkg::job_t              job_next;
  logic [1:0]                  mstep;
  logic [W-1:0]                opnd;
  logic [W-1:0]                opnd_next;
  logic [W-1:0]                acc;
  logic [W-1:0]                acc_next;
  logic [W-1:0]                base;
  logic [W-1:0]                lane_one;
  logic [W-1:0]                lane_two;
  logic [W-1:0]                lane_three;
  logic [W-1:0]                lane_four;
  logic [W-1:0]                hold_word;
  logic                        hold_upd;
  arxh_pkg::lane_t             hold_lane;
  logic                        hold_last;
  logic [arxh_pkg::LEN_W-1:0]  hold_length;

  logic                        take;
  logic                        take_first;
  logic                        take_plain;
  logic                        apply_word;
  logic                        mul_done;
  logic [W-1:0]                word_sel;
  logic                        upd_sel;
  arxh_pkg::lane_t             lane_sel;
  logic [W-1:0]                mult_k;
  logic [31:0]                 mul_a;
  logic [31:0]                 mul_b;
  logic [W-1:0]                product;
  logic [W-1:0]                fold;
  logic [W-1:0]                mix_one;
  logic [W-1:0]                mix_two;
  logic [W-1:0]                mix_three;
  logic [W-1:0]                mix_four;

  function automatic logic [W-1:0] rotl(input logic [W-1:0] x,
                                        input logic [arxh_pkg::ROT_W-1:0] k);
    logic [2*W-1:0] t;
    t = {x, x} << k;
    return t[2*W-1:W];
  endfunction

  always_comb begin
    take       = (state == S_IDLE) && !q_empty;
    take_first = take && q_item.first;
    take_plain = take && !q_item.first;
    q_pop      = take;
    apply_word = take_plain || (state == S_WORD);

    word_sel = (state == S_WORD) ? hold_word : q_item.word;
    upd_sel  = (state == S_WORD) ? hold_upd  : q_item.upd;
    lane_sel = (state == S_WORD) ? hold_lane : q_item.lane;

    mix_one   = rotl((lane_one   ^ word_sel) + lane_two,   cfg.rot_one);
    mix_two   = rotl((lane_two   ^ word_sel) + lane_three, cfg.rot_two);
    mix_three = rotl((lane_three ^ word_sel) + lane_four,  cfg.rot_three);
    mix_four  = rotl((lane_four  ^ word_sel) + lane_one,   cfg.rot_four);

    // Low 64 bits of the product from three 32x32 partial products.
    mult_k   = arxh_pkg::job_mult(job);
    mul_a    = (mstep == STEP_CROSS_A) ? opnd[W-1:32] : opnd[31:0];
    mul_b    = (mstep == STEP_CROSS_B) ? mult_k[W-1:32] : mult_k[31:0];
    product  = W'(mul_a) * W'(mul_b);
    acc_next = (mstep == STEP_LOW) ? product : acc + {product[31:0], 32'b0};
    mul_done = (state == S_MUL) && (mstep == STEP_CROSS_B);

    fold = lane_one ^ lane_two ^ lane_three ^ lane_four;
    case (job)
      arxh_pkg::JOB_BASE:  opnd_next = W'(hold_length);
      arxh_pkg::JOB_FIN_A: opnd_next = fold ^ (fold >> arxh_pkg::FIN_SHIFT_A);
      arxh_pkg::JOB_FIN_B: opnd_next = acc ^ (acc >> arxh_pkg::FIN_SHIFT_B);
      arxh_pkg::JOB_FIN_C: opnd_next = acc ^ (acc >> arxh_pkg::FIN_SHIFT_C);
      default:             opnd_next = base;
    endcase

    oq_push = (state == S_OUT) && !oq_full;
    oq_data = acc ^ (acc >> arxh_pkg::FIN_SHIFT_D);

    state_next = state;
    job_next   = job;
    case (state)
      S_IDLE: begin
        if (take_first) begin
          job_next   = arxh_pkg::JOB_BASE;
          state_next = S_LOAD;
        end else if (take_plain && q_item.last) begin
          job_next   = arxh_pkg::JOB_FIN_A;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          case (job)
            arxh_pkg::JOB_LANE_FOUR: state_next = S_WORD;
            arxh_pkg::JOB_FIN_C:     state_next = S_OUT;
            default: begin
              job_next   = arxh_pkg::job_t'(job + 3'd1);
              state_next = S_LOAD;
            end
          endcase
        end
      end
      S_WORD: begin
        if (hold_last) begin
          job_next   = arxh_pkg::JOB_FIN_A;
          state_next = S_LOAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (!oq_full) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= arxh_pkg::JOB_BASE;
      mstep <= STEP_LOW;
    end else begin
      state <= state_next;
      job   <= job_next;
      if (state == S_LOAD) begin
        mstep <= STEP_LOW;
      end else if (state == S_MUL) begin
        mstep <= mstep + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_one   <= '0;
      lane_two   <= '0;
      lane_three <= '0;
      lane_four  <= '0;
    end else if (mul_done) begin
      case (job)
        arxh_pkg::JOB_LANE_ONE:   lane_one   <= acc_next;
        arxh_pkg::JOB_LANE_TWO:   lane_two   <= acc_next;
        arxh_pkg::JOB_LANE_THREE: lane_three <= acc_next;
        arxh_pkg::JOB_LANE_FOUR:  lane_four  <= acc_next;
        default: ;
      endcase
    end else if (apply_word && upd_sel) begin
      case (lane_sel)
        arxh_pkg::LANE_ONE:   lane_one   <= mix_one;
        arxh_pkg::LANE_TWO:   lane_two   <= mix_two;
        arxh_pkg::LANE_THREE: lane_three <= mix_three;
        arxh_pkg::LANE_FOUR:  lane_four  <= mix_four;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      opnd <= opnd_next;
    end
    if (state == S_MUL) begin
      acc <= acc_next;
    end
    if (mul_done && (job == arxh_pkg::JOB_BASE)) begin
      base <= acc_next ^ cfg.seed;
    end
    if (take_first) begin
      hold_word   <= q_item.word;
      hold_upd    <= q_item.upd;
      hold_lane   <= q_item.lane;
      hold_last   <= q_item.last;
      hold_length <= q_item.length;
    end
  end

endmodule

### hdl/arx_four_lane_hash.sv
// ----------------------------------------------------------------------------
// ARX four-lane hash
// Streaming four-lane add-rotate-xor hash of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// Words enter through a queue-style port: a transfer happens when push is
// high and full is low. The first word of a message carries first_word and
// the byte length; the final word carries last_word. Each message yields one
// hash_value, shown while empty is low and taken by a pop transfer.
// The front end classifies words into a four-entry queue; the back end
// consumes one plain word per cycle while it is idle. A first word keeps
// it busy while the five seeding products run one after another on the
// shared 32x32 multiplier, each as a load step and its partial products,
// and the word itself is then applied in a state of its own. A last word
// then runs the three finalizer products and posts the result in the
// output state before the back end takes another word.
// Results wait in a two-entry output queue; while pop stays low the back end
// keeps taking words until a further result finds the output queue full,
// and then the input queue fills and full rises.
// Reset empties both queues, clears the lanes, length and position, and sets
// the seed to zero and the rotations to 11, 19, 35 and 47.
// Configuration writes via cfg_write, cfg_index and cfg_data take effect at
// once and are meant for idle periods only.
// ----------------------------------------------------------------------------
module arx_four_lane_hash #(
  parameter int unsigned LENGTH_BITS     = arxh_pkg::LENGTH_BITS_DEFAULT,
  parameter int unsigned IN_QUEUE_DEPTH  = arxh_pkg::IN_QUEUE_DEPTH,
  parameter int unsigned OUT_QUEUE_DEPTH = arxh_pkg::OUT_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [arxh_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [arxh_pkg::WORD_W-1:0]       cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [arxh_pkg::WORD_W-1:0]       data_word,
  input  logic                              first_word,
  input  logic                              last_word,
  input  logic [arxh_pkg::LEN_W-1:0]        message_length,
  output logic                              empty,
  input  logic                              pop,
  output logic [arxh_pkg::WORD_W-1:0]       hash_value
);

  arxh_pkg::cfg_t                 cfg;
  arxh_pkg::item_t                in_item;
  arxh_pkg::item_t                q_item;
  logic                           in_push;
  logic                           in_full;
  logic                           q_empty;
  logic                           q_pop;
  logic                           oq_full;
  logic                           oq_push;
  logic [arxh_pkg::WORD_W-1:0]    oq_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed      <= arxh_pkg::SEED_RESET;
      cfg.rot_one   <= arxh_pkg::ROT_ONE_RESET;
      cfg.rot_two   <= arxh_pkg::ROT_TWO_RESET;
      cfg.rot_three <= arxh_pkg::ROT_THREE_RESET;
      cfg.rot_four  <= arxh_pkg::ROT_FOUR_RESET;
    end else if (cfg_write) begin
      case (arxh_pkg::reg_index_t'(cfg_index))
        arxh_pkg::REG_SEED:      cfg.seed      <= cfg_data;
        arxh_pkg::REG_ROT_ONE:   cfg.rot_one   <= cfg_data[arxh_pkg::ROT_W-1:0];
        arxh_pkg::REG_ROT_TWO:   cfg.rot_two   <= cfg_data[arxh_pkg::ROT_W-1:0];
        arxh_pkg::REG_ROT_THREE: cfg.rot_three <= cfg_data[arxh_pkg::ROT_W-1:0];
        arxh_pkg::REG_ROT_FOUR:  cfg.rot_four  <= cfg_data[arxh_pkg::ROT_W-1:0];
        default: ;
      endcase
    end
  end

  arxh_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_word      (data_word),
    .first_word     (first_word),
    .last_word      (last_word),
    .message_length (message_length),
    .q_full         (in_full),
    .q_push         (in_push),
    .q_item         (in_item)
  );

  arxh_fifo #(
    .WIDTH ($bits(arxh_pkg::item_t)),
    .DEPTH (IN_QUEUE_DEPTH)
  ) u_in_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_push),
    .wr_data (in_item),
    .full    (in_full),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  arxh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .oq_full (oq_full),
    .oq_push (oq_push),
    .oq_data (oq_data)
  );

  arxh_fifo #(
    .WIDTH (arxh_pkg::WORD_W),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (oq_push),
    .wr_data (oq_data),
    .full    (oq_full),
    .rd_en   (pop),
    .rd_data (hash_value),
    .empty   (empty)
  );

endmodule

### hdl/arxh_checker.sv
// ----------------------------------------------------------------------------
// ARX hash port checker
// Watches the top-level ports: checks the state after reset, that a waiting
// result holds, and that results never outnumber accepted last words.
module arxh_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        last_word,
  input logic        empty,
  input logic        pop,
  input logic [63:0] hash_value
);

  logic [7:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 8'(push && !full && last_word) - 8'(pop && !empty);
    end
  end

  a_reset_clears : assert property (@(posedge clk)
    $past(rst) |-> empty && !full)
    else $error("Queues not empty after reset.");

  a_result_holds : assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(hash_value))
    else $error("Waiting result changed before its transfer.");

  a_no_extra_result : assert property (@(posedge clk) disable iff (rst)
    !empty |-> pending != 8'd0)
    else $error("Result shown without an outstanding last word.");

  a_no_negative : assert property (@(posedge clk) disable iff (rst)
    pop && !empty |-> pending != 8'd0)
    else $error("More results transferred than last words accepted.");

endmodule

bind arx_four_lane_hash arxh_checker u_checker (.*);

### test/testbench.sv
// ----------------------------------------------------------------------------
// ARX four-lane hash testbench
// Streams messages through the hash block and compares every hash it returns
// against a local prediction of the lanes and the finalizer. Directed
// messages cover the edge cases. Several register settings and random
// message streams follow, with random idling on both sides and long
// output stalls that make the block fill up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam longint unsigned POSITION_CAP = 64'h0FFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        push;
  logic        full;
  logic [63:0] data_word;
  logic        first_word;
  logic        last_word;
  logic [31:0] message_length;
  logic        empty;
  logic        pop;
  logic [63:0] hash_value;

  logic [63:0] hash_seed;
  logic [5:0]  rot_amount [4];
  logic [63:0] lane [4];
  logic [31:0] msg_bytes;
  longint unsigned word_index;

  logic [63:0] expected_hashes [$];
  logic [63:0] wanted_hash;
  int          error_count;
  int          words_sent;
  int          quiet_cycles;
  int          pop_hold_cycles;
  bit          sender_idles;
  bit          receiver_idles;

  arx_four_lane_hash dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .data_word      (data_word),
    .first_word     (first_word),
    .last_word      (last_word),
    .message_length (message_length),
    .empty          (empty),
    .pop            (pop),
    .hash_value     (hash_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rotate_left(input logic [63:0] x, input logic [5:0] k);
    if (k == 6'd0) begin
      return x;
    end
    return (x << k) | (x >> (64 - int'(k)));
  endfunction

  function automatic logic [63:0] fold_and_finalize();
    logic [63:0] h;
    h = lane[0] ^ lane[1] ^ lane[2] ^ lane[3];
    h = h ^ (h >> 29);
    h = h * arxh_pkg::MUL_A;
    h = h ^ (h >> 31);
    h = h * arxh_pkg::MUL_B;
    h = h ^ (h >> 37);
    h = h * arxh_pkg::PHI;
    h = h ^ (h >> 41);
    return h;
  endfunction

  function automatic void absorb_word(input logic [63:0] data, input bit first, input bit last,
                                      input logic [31:0] len);
    logic [63:0] base;
    logic [63:0] block_words;
    logic [63:0] start;
    logic [63:0] remaining;
    logic [63:0] w;
    int          i;
    w = data;
    if (first) begin
      msg_bytes = len;
      base = hash_seed ^ (64'(msg_bytes) * arxh_pkg::PHI);
      lane[0] = base * arxh_pkg::PHI;
      lane[1] = base * arxh_pkg::MUL_A;
      lane[2] = base * arxh_pkg::MUL_B;
      lane[3] = base * arxh_pkg::MUL_C;
      word_index = 0;
    end
    block_words = (64'(msg_bytes) / 64'd32) * 64'd4;
    start = 64'(word_index) * 64'd8;
    if (64'(word_index) < block_words) begin
      i = int'(word_index % 4);
      lane[i] = rotate_left((lane[i] ^ w) + lane[(i + 1) % 4], rot_amount[i]);
    end else if (start < 64'(msg_bytes)) begin
      remaining = 64'(msg_bytes) - start;
      if (remaining < 64'd8) begin
        w = w & ((64'd1 << (remaining * 8)) - 64'd1);
      end
      lane[0] = rotate_left((lane[0] ^ w) + lane[1], rot_amount[0]);
    end
    if (word_index < POSITION_CAP) begin
      word_index++;
    end
    if (last) begin
      expected_hashes.push_back(fold_and_finalize());
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  task automatic send_word(input logic [63:0] data, input bit first, input bit last,
                           input logic [31:0] len);
    @(negedge clk);
    while (sender_idles && $urandom_range(0, 99) < 31) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    data_word = data;
    first_word = first;
    last_word = last;
    message_length = len;
    do begin
      @(posedge clk);
    end while (full);
    absorb_word(data, first, last, len);
    words_sent++;
  endtask

  function automatic int words_for(input logic [31:0] len);
    return (len == 32'd0) ? 1 : int'((64'(len) + 64'd7) / 64'd8);
  endfunction

  task automatic send_message(input logic [31:0] len, input int words, input bit closes);
    for (int n = 0; n < words; n++) begin
      send_word(random_word(), n == 0, closes && (n == words - 1), (n == 0) ? len : $urandom);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    push = 1'b0;
    while (expected_hashes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input arxh_pkg::reg_index_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    case (idx)
      arxh_pkg::REG_SEED:      hash_seed = value;
      arxh_pkg::REG_ROT_ONE:   rot_amount[0] = value[5:0];
      arxh_pkg::REG_ROT_TWO:   rot_amount[1] = value[5:0];
      arxh_pkg::REG_ROT_THREE: rot_amount[2] = value[5:0];
      arxh_pkg::REG_ROT_FOUR:  rot_amount[3] = value[5:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [63:0] seed_value, input logic [5:0] r1,
                           input logic [5:0] r2, input logic [5:0] r3, input logic [5:0] r4);
    settle();
    write_reg(arxh_pkg::REG_SEED, seed_value);
    write_reg(arxh_pkg::REG_ROT_ONE, {58'd0, r1});
    write_reg(arxh_pkg::REG_ROT_TWO, {58'd0, r2});
    write_reg(arxh_pkg::REG_ROT_THREE, {58'd0, r3});
    write_reg(arxh_pkg::REG_ROT_FOUR, {58'd0, r4});
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic test_directed();
    // Words before any first word run against the cleared state.
    send_word(random_word(), 1'b0, 1'b0, $urandom);
    send_word(random_word(), 1'b0, 1'b1, $urandom);
    send_message(32'd0, 1, 1'b1);
    send_message(32'd1, 1, 1'b1);
    send_word(64'd0, 1'b1, 1'b1, 32'd8);
    send_message(32'd9, 2, 1'b1);
    send_word({64{1'b1}}, 1'b1, 1'b0, 32'd32);
    send_word({64{1'b1}}, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_word({64{1'b1}}, 1'b0, 1'b0, 32'd0);
    send_word({64{1'b1}}, 1'b0, 1'b1, 32'hFFFF_FFFF);
    send_message(32'd37, 5, 1'b1);
    // A huge length closed after two words.
    send_message(32'hFFFF_FFFF, 2, 1'b1);
    // Words past the end of a five-byte message.
    send_message(32'd5, 3, 1'b1);
    // State is kept after a result; the extra words fall past the length.
    send_word(random_word(), 1'b0, 1'b0, $urandom);
    send_word(random_word(), 1'b0, 1'b1, $urandom);
  endtask

  task automatic test_register_settings();
    configure({64{1'b1}}, 6'd63, 6'd63, 6'd63, 6'd63);
    for (int m = 0; m < 6; m++) send_message(32'd40 + m, words_for(32'd40 + m), 1'b1);
    configure(64'd0, 6'd1, 6'd1, 6'd1, 6'd1);
    for (int m = 0; m < 6; m++) send_message(32'd33 + 7 * m, words_for(32'd33 + 7 * m), 1'b1);
    // Zero rotation leaves every lane sum unrotated.
    configure(random_word(), 6'd0, 6'd0, 6'd0, 6'd0);
    for (int m = 0; m < 6; m++) send_message(32'd64 - m, words_for(32'd64 - m), 1'b1);
    configure(random_word(), 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
    for (int m = 0; m < 6; m++) send_message(32'd96 + m, words_for(32'd96 + m), 1'b1);
  endtask

  task automatic random_traffic(input int target);
    int          kind;
    logic [31:0] len;
    int          stop_at;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(0, 80);
      if (kind < 70) begin
        send_message(len, words_for(len), 1'b1);
      end else if (kind < 80) begin
        len = $urandom_range(81, 300);
        send_message(len, words_for(len), 1'b1);
      end else if (kind < 86) begin
        send_message($urandom, $urandom_range(1, 6), 1'b1);
      end else if (kind < 91) begin
        send_message(len, words_for(len) + $urandom_range(1, 3), 1'b1);
      end else if (kind < 95) begin
        send_message(len, $urandom_range(1, words_for(len)), 1'b0);
      end else begin
        send_word(random_word(), 1'b0, 1'($urandom_range(0, 1)), $urandom);
      end
    end
  endtask

  task automatic test_random_streams();
    for (int round = 0; round < 3; round++) begin
      configure(random_word(), 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
      sender_idles = (round != 1);
      receiver_idles = (round != 1);
      random_traffic(400);
    end
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  task automatic test_backpressure();
    settle();
    sender_idles = 1'b0;
    pop_hold_cycles = 400;
    for (int m = 0; m < 30; m++) begin
      send_message(32'($urandom_range(0, 8)), 1, 1'b1);
    end
    // The sender waits for every hash before it carries on.
    settle();
    for (int m = 0; m < 10; m++) begin
      send_message(32'($urandom_range(0, 40)), words_for(32'd40), 1'b1);
    end
    sender_idles = 1'b1;
  endtask

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (pop_hold_cycles > 0) begin
        pop = 1'b0;
        pop_hold_cycles--;
      end else begin
        pop = !(receiver_idles && $urandom_range(0, 99) < 31);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("hash %h with no message pending", hash_value));
      end else begin
        wanted_hash = expected_hashes.pop_front();
        if (hash_value !== wanted_hash) begin
          report_mismatch($sformatf("hash_value %h, expected %h", hash_value, wanted_hash));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[arx_four_lane_hash] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    push = 1'b0;
    data_word = '0;
    first_word = 1'b0;
    last_word = 1'b0;
    message_length = '0;
    error_count = 0;
    words_sent = 0;
    quiet_cycles = 0;
    pop_hold_cycles = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    hash_seed = '0;
    rot_amount[0] = 6'd11;
    rot_amount[1] = 6'd19;
    rot_amount[2] = 6'd35;
    rot_amount[3] = 6'd47;
    for (int i = 0; i < 4; i++) lane[i] = '0;
    msg_bytes = '0;
    word_index = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_register_settings();
    test_backpressure();
    test_random_streams();
    settle();

    if (error_count == 0) begin
      $display("[arx_four_lane_hash] OK");
    end else begin
      $display("[arx_four_lane_hash] ERROR");
    end
    $finish;
  end

endmodule
